[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
		else $error("%m: assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
		else $error("%m: forbidden condition");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

[rtl/mdd_pkg.sv]
// ----------------------------------------------------------------------------
// mdd_pkg
// Types, constants and constellation ROM for the minimum distance demapper.
// ----------------------------------------------------------------------------
`default_nettype none

package mdd_pkg;

	localparam int MAX_POINTS  = 16;
	localparam int SAMPLE_BITS = 16;

	localparam int COORD_W   = 16;
	localparam int TAB_DEPTH = 16;
	localparam int IDX_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int DX_W      = ((SAMPLE_BITS > COORD_W) ? SAMPLE_BITS : COORD_W) + 1;
	localparam int DIST_W    = 2 * DX_W + 1;
	localparam int NUM_GRP   = (MAX_POINTS + 3) / 4;
	localparam int GRP_W     = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
	localparam int OUT_IDX_W = 4;
	localparam int CNT_W     = 5;

	localparam int KIND_W   = 2;
	localparam int BPS_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOD_KIND = 2'd0,
		REG_BITS_PER_SYM = 2'd1
	} cfg_reg_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAM = 2'd0,
		KIND_PSK = 2'd1,
		KIND_QAM = 2'd2
	} mod_kind_t;

	typedef enum logic [3:0] {
		CID_NONE  = 4'd0,
		CID_BIN   = 4'd1,
		CID_QUAD  = 4'd2,
		CID_PAM4  = 4'd3,
		CID_PAM8  = 4'd4,
		CID_PAM16 = 4'd5,
		CID_PSK8  = 4'd6,
		CID_PSK16 = 4'd7,
		CID_QAM8  = 4'd8,
		CID_QAM16 = 4'd9
	} const_id_t;

	localparam int NUM_CONST = 10;

	typedef struct packed {
		logic              ok;
		logic [DIST_W-1:0] dist_sq;
		logic [IDX_W-1:0]  idx;
	} cand_t;

	localparam logic [CNT_W-1:0] PT_COUNT [NUM_CONST] = '{
		5'd0, 5'd2, 5'd4, 5'd4, 5'd8, 5'd16, 5'd8, 5'd16, 5'd8, 5'd16
	};

	localparam coord_t PT_I [NUM_CONST][TAB_DEPTH] = '{
		'{default: 16'sd0},
		'{-16'sd4096, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
		  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd4096, 16'sd0, -16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
		  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{-16'sd5495, -16'sd1832, 16'sd1832, 16'sd5495, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
		  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{-16'sd6257, -16'sd4469, -16'sd2681, -16'sd894,
		  16'sd894, 16'sd2681, 16'sd4469, 16'sd6257,
		  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{-16'sd6664, -16'sd5776, -16'sd4887, -16'sd3998,
		  -16'sd3110, -16'sd2221, -16'sd1333, -16'sd444,
		  16'sd444, 16'sd1333, 16'sd2221, 16'sd3110,
		  16'sd3998, 16'sd4887, 16'sd5776, 16'sd6664},
		'{16'sd4096, 16'sd2896, 16'sd0, -16'sd2896,
		  -16'sd4096, -16'sd2896, 16'sd0, 16'sd2896,
		  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd4096, 16'sd3784, 16'sd2896, 16'sd1567,
		  16'sd0, -16'sd1567, -16'sd2896, -16'sd3784,
		  -16'sd4096, -16'sd3784, -16'sd2896, -16'sd1567,
		  16'sd0, 16'sd1567, 16'sd2896, 16'sd3784},
		'{16'sd5017, 16'sd1672, -16'sd1672, -16'sd5017,
		  -16'sd5017, -16'sd1672, 16'sd1672, 16'sd5017,
		  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{-16'sd3886, -16'sd1295, 16'sd1295, 16'sd3886,
		  16'sd3886, 16'sd1295, -16'sd1295, -16'sd3886,
		  -16'sd3886, -16'sd1295, 16'sd1295, 16'sd3886,
		  16'sd3886, 16'sd1295, -16'sd1295, -16'sd3886}
	};

	localparam coord_t PT_Q [NUM_CONST][TAB_DEPTH] = '{
		'{default: 16'sd0},
		'{default: 16'sd0},
		'{16'sd0, 16'sd4096, 16'sd0, -16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
		  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{default: 16'sd0},
		'{default: 16'sd0},
		'{default: 16'sd0},
		'{16'sd0, 16'sd2896, 16'sd4096, 16'sd2896,
		  16'sd0, -16'sd2896, -16'sd4096, -16'sd2896,
		  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd0, 16'sd1567, 16'sd2896, 16'sd3784,
		  16'sd4096, 16'sd3784, 16'sd2896, 16'sd1567,
		  16'sd0, -16'sd1567, -16'sd2896, -16'sd3784,
		  -16'sd4096, -16'sd3784, -16'sd2896, -16'sd1567},
		'{16'sd1672, 16'sd1672, 16'sd1672, 16'sd1672,
		  -16'sd1672, -16'sd1672, -16'sd1672, -16'sd1672,
		  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd3886, 16'sd3886, 16'sd3886, 16'sd3886,
		  16'sd1295, 16'sd1295, 16'sd1295, 16'sd1295,
		  -16'sd1295, -16'sd1295, -16'sd1295, -16'sd1295,
		  -16'sd3886, -16'sd3886, -16'sd3886, -16'sd3886}
	};

	function automatic const_id_t const_select(
		input logic [KIND_W-1:0] kind,
		input logic [BPS_W-1:0]  bps
	);
		const_id_t cid;
		cid = CID_NONE;
		unique case (bps)
			3'd1: begin
				if (kind != 2'd3)
					cid = CID_BIN;
			end
			3'd2: begin
				if (kind == KIND_PAM)
					cid = CID_PAM4;
				else if (kind != 2'd3)
					cid = CID_QUAD;
			end
			3'd3: begin
				unique case (kind)
					KIND_PAM: cid = CID_PAM8;
					KIND_PSK: cid = CID_PSK8;
					KIND_QAM: cid = CID_QAM8;
					default:  cid = CID_NONE;
				endcase
			end
			3'd4: begin
				unique case (kind)
					KIND_PAM: cid = CID_PAM16;
					KIND_PSK: cid = CID_PSK16;
					KIND_QAM: cid = CID_QAM16;
					default:  cid = CID_NONE;
				endcase
			end
			default: cid = CID_NONE;
		endcase
		return cid;
	endfunction

	// Strict compare keeps the earlier (lower index) candidate on ties.
	function automatic cand_t cand_pick(input cand_t a, input cand_t b);
		if (b.ok && (!a.ok || (b.dist_sq < a.dist_sq)))
			return b;
		return a;
	endfunction

endpackage

`default_nettype wire

[rtl/min_distance_symbol_demapper_unit.sv]
// ----------------------------------------------------------------------------
// min_distance_symbol_demapper_unit
// Hard-decision nearest-point demapper for PAM, PSK and QAM constellations.
// ----------------------------------------------------------------------------
// Takes one I/Q sample (signed Q3.12) per item and returns the index of the
// nearest point of the configured constellation by squared distance, lowest
// index on ties; an unsupported kind/size pair returns index 0. The pipeline
// has four register stages (input, distance lanes, group minimum, output),
// and one item is accepted every cycle while the output is taken. A stalled
// output blocks the input only once every stage holds an item. Configuration
// writes are taken at any time (cfg_ready is always high) and must be made
// while idle.
`default_nettype none

`include "assert_macros.svh"

module min_distance_symbol_demapper_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [mdd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mdd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [mdd_pkg::SAMPLE_BITS-1:0] rx_inphase,
	input  wire logic signed [mdd_pkg::SAMPLE_BITS-1:0] rx_quadrature,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [mdd_pkg::OUT_IDX_W-1:0]          symbol_index
);
	import mdd_pkg::*;

	logic [KIND_W-1:0] mod_kind_q;
	logic [BPS_W-1:0]  bps_q;
	logic              valid_s1;
	logic              ready_s1;
	sample_t           ri_s1;
	sample_t           rq_s1;
	const_id_t         cid_s1;
	logic              ready_s2;
	logic              valid_s2;
	logic              ready_s3;
	cand_t             lanes_s2 [MAX_POINTS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_kind_q <= KIND_W'(KIND_QAM);
			bps_q      <= BPS_W'(2);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MOD_KIND:     mod_kind_q <= cfg_data[KIND_W-1:0];
				REG_BITS_PER_SYM: bps_q      <= cfg_data[BPS_W-1:0];
				default:          ;
			endcase
		end
	end

	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			ri_s1  <= rx_inphase;
			rq_s1  <= rx_quadrature;
			cid_s1 <= const_select(mod_kind_q, bps_q);
		end
	end

	mdd_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_s1),
		.ready_o (ready_s2),
		.ri_i    (ri_s1),
		.rq_i    (rq_s1),
		.cid_i   (cid_s1),
		.valid_o (valid_s2),
		.ready_i (ready_s3),
		.lanes_o (lanes_s2)
	);

	mdd_min u_min (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_s2),
		.ready_o (ready_s3),
		.lanes_i (lanes_s2),
		.valid_o (out_valid),
		.stall_i (out_stall),
		.index_o (symbol_index)
	);

	`ASSERT_CLK(a_stall_only_full, clk, arst_n, in_stall |-> out_valid && out_stall && valid_s1 && valid_s2)
	`ASSERT_CLK(a_bin_select, clk, arst_n, in_valid && !in_stall && (bps_q == BPS_W'(1)) && (mod_kind_q != 2'd3) |=> cid_s1 == CID_BIN)

endmodule

`default_nettype wire

[rtl/mdd_dist.sv]
// ----------------------------------------------------------------------------
// mdd_dist
// Squared distance lanes: one lane per constellation point, registered.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mdd_dist (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  valid_i,
	output logic                       ready_o,
	input  wire mdd_pkg::sample_t      ri_i,
	input  wire mdd_pkg::sample_t      rq_i,
	input  wire mdd_pkg::const_id_t    cid_i,
	output logic                       valid_o,
	input  wire logic                  ready_i,
	output mdd_pkg::cand_t             lanes_o [mdd_pkg::MAX_POINTS]
);
	import mdd_pkg::*;

	logic                     valid_s2;
	cand_t                    lanes_s2 [MAX_POINTS];
	cand_t                    lanes_d  [MAX_POINTS];
	logic [CNT_W-1:0]         count_d;

	always_comb begin
		logic signed [DX_W-1:0]   dx;
		logic signed [DX_W-1:0]   dy;
		logic signed [2*DX_W-1:0] sx;
		logic signed [2*DX_W-1:0] sy;
		count_d = PT_COUNT[cid_i];
		for (int k = 0; k < MAX_POINTS; k++) begin
			dx = DX_W'(ri_i) - DX_W'(PT_I[cid_i][k]);
			dy = DX_W'(rq_i) - DX_W'(PT_Q[cid_i][k]);
			sx = dx * dx;
			sy = dy * dy;
			lanes_d[k].ok      = (CNT_W'(k) < count_d);
			lanes_d[k].dist_sq = DIST_W'($unsigned(sx)) + DIST_W'($unsigned(sy));
			lanes_d[k].idx     = IDX_W'(k);
		end
	end

	assign ready_o = !valid_s2 || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_o) begin
			valid_s2 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			lanes_s2 <= lanes_d;
		end
	end

	assign valid_o = valid_s2;
	assign lanes_o = lanes_s2;

	`ASSERT_CLK(a_lane0_ok, clk, arst_n, valid_i && ready_o && (cid_i != CID_NONE) |=> lanes_s2[0].ok)
	`ASSERT_CLK(a_none_no_lane, clk, arst_n, valid_i && ready_o && (cid_i == CID_NONE) |=> !lanes_s2[0].ok)

endmodule

`default_nettype wire

[rtl/mdd_min.sv]
// ----------------------------------------------------------------------------
// mdd_min
// Two-stage minimum search over the distance lanes; output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mdd_min (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              valid_i,
	output logic                                   ready_o,
	input  wire mdd_pkg::cand_t                    lanes_i [mdd_pkg::MAX_POINTS],
	output logic                                   valid_o,
	input  wire logic                              stall_i,
	output logic [mdd_pkg::OUT_IDX_W-1:0]          index_o
);
	import mdd_pkg::*;

	logic              valid_s3;
	logic              valid_s4;
	logic              ready_s4;
	cand_t             grp_s3 [NUM_GRP];
	cand_t             grp_d  [NUM_GRP];
	cand_t             best_d;
	logic [IDX_W-1:0]  idx_s4;

	always_comb begin
		cand_t c;
		for (int g = 0; g < NUM_GRP; g++) begin
			grp_d[g] = lanes_i[g*4];
			for (int j = 1; j < 4; j++) begin
				if (g*4 + j < MAX_POINTS) begin
					c = lanes_i[(g*4 + j) % MAX_POINTS];
					grp_d[g] = cand_pick(grp_d[g], c);
				end
			end
		end
	end

	always_comb begin
		best_d = grp_s3[0];
		for (int g = 1; g < NUM_GRP; g++)
			best_d = cand_pick(best_d, grp_s3[g]);
	end

	assign ready_s4 = !valid_s4 || !stall_i;
	assign ready_o  = !valid_s3 || ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_o)
				valid_s3 <= valid_i;
			if (ready_s4)
				valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i)
			grp_s3 <= grp_d;
		if (ready_s4 && valid_s3)
			idx_s4 <= best_d.ok ? best_d.idx : '0;
	end

	assign valid_o = valid_s4;
	assign index_o = OUT_IDX_W'(idx_s4);

	`ASSERT_CLK(a_s3_hold, clk, arst_n, valid_s3 && !ready_s4 |=> valid_s3 && $stable(grp_s3[0]))
	`ASSERT_NEVER(a_idx_range, clk, arst_n, valid_s4 && (int'(idx_s4) >= MAX_POINTS))

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the minimum distance symbol demapper.
// ----------------------------------------------------------------------------
// Drives I/Q samples through the valid/stall input channel and compares every
// decided symbol index against an in-bench nearest-point search over its own
// copy of the constellation tables. It sweeps all families and sizes,
// including unsupported settings, register masking and writes to spare
// indexes. Random gaps and output stalls vary by phase, and some phases run
// with no idling at all.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import mdd_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 11;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PIPE_DRAIN    = 12;
	localparam int MAX_SHOWN     = 10;
	localparam int RANDOM_PHASES = 40;
	localparam int PHASE_ITEMS   = 44;
	localparam int LIM_HI        = 2 ** (SAMPLE_BITS - 1) - 1;
	localparam int LIM_LO        = -(2 ** (SAMPLE_BITS - 1));

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam logic [KIND_W-1:0]    KIND_NONE   = 2'd3;

	typedef enum int {
		SET_NONE, SET_BIN, SET_QUAD, SET_PAM4, SET_PAM8, SET_PAM16,
		SET_PSK8, SET_PSK16, SET_QAM8, SET_QAM16
	} point_set_e;

	localparam int BIN_I [2]  = '{-4096, 4096};
	localparam int QUAD_I [4] = '{4096, 0, -4096, 0};
	localparam int QUAD_Q [4] = '{0, 4096, 0, -4096};
	localparam int PAM4_I [4] = '{-5495, -1832, 1832, 5495};
	localparam int PAM8_I [8] = '{-6257, -4469, -2681, -894, 894, 2681, 4469, 6257};
	localparam int PAM16_I [16] = '{-6664, -5776, -4887, -3998, -3110, -2221, -1333, -444,
		444, 1333, 2221, 3110, 3998, 4887, 5776, 6664};
	localparam int PSK8_I [8] = '{4096, 2896, 0, -2896, -4096, -2896, 0, 2896};
	localparam int PSK8_Q [8] = '{0, 2896, 4096, 2896, 0, -2896, -4096, -2896};
	localparam int PSK16_I [16] = '{4096, 3784, 2896, 1567, 0, -1567, -2896, -3784,
		-4096, -3784, -2896, -1567, 0, 1567, 2896, 3784};
	localparam int PSK16_Q [16] = '{0, 1567, 2896, 3784, 4096, 3784, 2896, 1567,
		0, -1567, -2896, -3784, -4096, -3784, -2896, -1567};
	localparam int QAM8_I [8] = '{5017, 1672, -1672, -5017, -5017, -1672, 1672, 5017};
	localparam int QAM8_Q [8] = '{1672, 1672, 1672, 1672, -1672, -1672, -1672, -1672};
	localparam int QAM16_I [16] = '{-3886, -1295, 1295, 3886, 3886, 1295, -1295, -3886,
		-3886, -1295, 1295, 3886, 3886, 1295, -1295, -3886};
	localparam int QAM16_Q [16] = '{3886, 3886, 3886, 3886, 1295, 1295, 1295, 1295,
		-1295, -1295, -1295, -1295, -3886, -3886, -3886, -3886};

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;
	logic                   in_valid      = 1'b0;
	logic                   in_stall;
	sample_t                rx_inphase    = '0;
	sample_t                rx_quadrature = '0;
	logic                   out_valid;
	logic                   out_stall     = 1'b1;
	logic [OUT_IDX_W-1:0]   symbol_index;

	logic [KIND_W-1:0] model_kind = KIND_QAM;
	logic [BPS_W-1:0]  model_bps  = 3'd2;

	logic [OUT_IDX_W-1:0] predicted_symbols [$];
	bit in_gaps_on    = 1'b1;
	bit out_stalls_on = 1'b1;
	int samples_sent    = 0;
	int symbols_checked = 0;
	int symbol_errors   = 0;
	int config_writes   = 0;
	int cycles          = 0;

	min_distance_symbol_demapper_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_inphase    (rx_inphase),
		.rx_quadrature (rx_quadrature),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.symbol_index  (symbol_index)
	);

	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d symbols pending", cycles,
				predicted_symbols.size());
			$display("** min_distance_symbol_demapper_unit: FAILED **");
			$finish;
		end
	end

	function automatic point_set_e select_set(logic [KIND_W-1:0] kind, logic [BPS_W-1:0] bps);
		point_set_e s;
		s = SET_NONE;
		if (kind != KIND_NONE) begin
			case (bps)
				3'd1: s = SET_BIN;
				3'd2: s = (kind == KIND_PAM) ? SET_PAM4 : SET_QUAD;
				3'd3: s = (kind == KIND_PAM) ? SET_PAM8 : (kind == KIND_PSK) ? SET_PSK8 : SET_QAM8;
				3'd4: s = (kind == KIND_PAM) ? SET_PAM16 :
					(kind == KIND_PSK) ? SET_PSK16 : SET_QAM16;
				default: s = SET_NONE;
			endcase
		end
		return s;
	endfunction

	function automatic int set_size(point_set_e s);
		int n;
		case (s)
			SET_BIN: n = 2;
			SET_QUAD, SET_PAM4: n = 4;
			SET_PAM8, SET_PSK8, SET_QAM8: n = 8;
			SET_PAM16, SET_PSK16, SET_QAM16: n = 16;
			default: n = 0;
		endcase
		return (n > MAX_POINTS) ? MAX_POINTS : n;
	endfunction

	function automatic void point_at(input point_set_e s, input int k, output int px,
		output int py);
		px = 0;
		py = 0;
		case (s)
			SET_BIN: px = BIN_I[k];
			SET_QUAD: begin
				px = QUAD_I[k];
				py = QUAD_Q[k];
			end
			SET_PAM4: px = PAM4_I[k];
			SET_PAM8: px = PAM8_I[k];
			SET_PAM16: px = PAM16_I[k];
			SET_PSK8: begin
				px = PSK8_I[k];
				py = PSK8_Q[k];
			end
			SET_PSK16: begin
				px = PSK16_I[k];
				py = PSK16_Q[k];
			end
			SET_QAM8: begin
				px = QAM8_I[k];
				py = QAM8_Q[k];
			end
			SET_QAM16: begin
				px = QAM16_I[k];
				py = QAM16_Q[k];
			end
			default: ;
		endcase
	endfunction

	function automatic logic [OUT_IDX_W-1:0] nearest_point_index(sample_t si, sample_t sq);
		point_set_e s;
		int n, k, px, py;
		longint dx, dy, sq_dist, best_sq;
		logic [OUT_IDX_W-1:0] best;
		s = select_set(model_kind, model_bps);
		n = set_size(s);
		best = '0;
		best_sq = 0;
		for (k = 0; k < n; k++) begin
			point_at(s, k, px, py);
			dx = longint'(si) - longint'(px);
			dy = longint'(sq) - longint'(py);
			sq_dist = dx * dx + dy * dy;
			if (k == 0 || sq_dist < best_sq) begin
				best_sq = sq_dist;
				best = k[OUT_IDX_W-1:0];
			end
		end
		return best;
	endfunction

	function automatic sample_t clamp_sample(int v);
		if (v > LIM_HI)
			return sample_t'(LIM_HI);
		if (v < LIM_LO)
			return sample_t'(LIM_LO);
		return sample_t'(v);
	endfunction

	function automatic sample_t rail_value(int sel);
		case (sel)
			0: return sample_t'(LIM_LO);
			1: return sample_t'(LIM_HI);
			2: return '0;
			default: return '1;
		endcase
	endfunction

	task automatic draw_sample(output sample_t si, output sample_t sq);
		point_set_e s;
		int n, pick, ai, aq, bi, bq;
		s = select_set(model_kind, model_bps);
		n = set_size(s);
		pick = $urandom_range(0, 99);
		if (n == 0 || pick < 20) begin
			si = sample_t'($urandom);
			sq = sample_t'($urandom);
		end else if (pick < 70) begin
			point_at(s, $urandom_range(0, n - 1), ai, aq);
			si = clamp_sample(ai + int'($urandom_range(0, 1200)) - 600);
			sq = clamp_sample(aq + int'($urandom_range(0, 1200)) - 600);
		end else if (pick < 88) begin
			point_at(s, $urandom_range(0, n - 1), ai, aq);
			point_at(s, $urandom_range(0, n - 1), bi, bq);
			si = clamp_sample((ai + bi) / 2);
			sq = clamp_sample((aq + bq) / 2);
		end else begin
			si = rail_value($urandom_range(0, 3));
			sq = rail_value($urandom_range(0, 3));
		end
	endtask

	task automatic send_sample(input sample_t si, input sample_t sq);
		int gap;
		gap = in_gaps_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_inphase <= si;
		rx_quadrature <= sq;
		do @(posedge clk); while (in_stall);
		predicted_symbols.push_back(nearest_point_index(si, sq));
		samples_sent++;
	endtask

	task automatic check_symbol(input logic [OUT_IDX_W-1:0] got);
		logic [OUT_IDX_W-1:0] want;
		if (predicted_symbols.size() == 0) begin
			symbol_errors++;
			if (symbol_errors <= MAX_SHOWN)
				$display("unexpected symbol_index %0d with no sample pending", got);
			return;
		end
		want = predicted_symbols.pop_front();
		symbols_checked++;
		if (got !== want) begin
			symbol_errors++;
			if (symbol_errors <= MAX_SHOWN)
				$display("symbol %0d: symbol_index expected %0d, got %0d (kind %0d, bps %0d)",
					symbols_checked, want, got, model_kind, model_bps);
		end
	endtask

	initial begin : result_sink
		int hold;
		while (!arst_n) @(posedge clk);
		forever begin
			hold = out_stalls_on ? $urandom_range(0, 6) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			check_symbol(symbol_index);
		end
	end

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (predicted_symbols.size() != 0) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after its last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MOD_KIND: model_kind = data[KIND_W-1:0];
			REG_BITS_PER_SYM: model_bps = data;
			default: ;
		endcase
		config_writes++;
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] kind, input logic [BPS_W-1:0] bps);
		settle();
		write_reg(REG_MOD_KIND, kind);
		write_reg(REG_BITS_PER_SYM, bps);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_state();
		send_sample('0, '0);
		send_sample(16'sd2048, 16'sd2048);
		send_sample(rail_value(0), rail_value(0));
		send_sample(rail_value(1), rail_value(1));
		send_sample(rail_value(0), rail_value(1));
	endtask

	task automatic test_each_constellation();
		int j;
		j = 0;
		for (int kind = KIND_PAM; kind <= KIND_QAM; kind++) begin
			for (int bps = 1; bps <= 4; bps++) begin
				configure(kind[CFG_DATA_W-1:0], bps[BPS_W-1:0]);
				send_sample(rail_value(j % 4), rail_value((j + 1) % 4));
				j++;
			end
		end
	endtask

	task automatic test_unsupported_modes();
		configure({1'b0, KIND_NONE}, 3'd2);
		send_sample(16'sd4096, 16'sd0);
		configure({1'b0, KIND_PAM}, 3'd0);
		send_sample(16'sd5495, 16'sd0);
		configure({1'b0, KIND_QAM}, 3'd7);
		send_sample(16'sd3886, -16'sd3886);
		configure({1'b0, KIND_PSK}, 3'd5);
		send_sample(-16'sd2896, 16'sd2896);
	endtask

	task automatic test_register_masking();
		configure({1'b1, KIND_PSK}, 3'd3);
		send_sample(-16'sd2896, -16'sd2896);
		settle();
		write_reg(REG_SPARE_A, 3'd0);
		write_reg(REG_SPARE_B, 3'd7);
		cfg_valid <= 1'b0;
		send_sample(16'sd0, -16'sd4096);
	endtask

	task automatic test_random_traffic();
		sample_t si, sq;
		logic [CFG_DATA_W-1:0] kind;
		logic [BPS_W-1:0] bps;
		int r;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			r = $urandom_range(0, 9);
			if (phase < 12) begin
				kind = CFG_DATA_W'(phase % 3);
				bps = BPS_W'(phase / 3 + 1);
			end else if (r == 0) begin
				kind = CFG_DATA_W'($urandom);
				bps = BPS_W'($urandom);
			end else begin
				kind = {1'($urandom), 2'($urandom_range(0, 2))};
				bps = BPS_W'($urandom_range(1, 4));
			end
			configure(kind, bps);
			if (r == 1) begin
				settle();
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
				cfg_valid <= 1'b0;
			end
			in_gaps_on = (phase % 4 == 0) || (phase % 4 == 1);
			out_stalls_on = (phase % 4 == 0) || (phase % 4 == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				draw_sample(si, sq);
				send_sample(si, sq);
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_each_constellation();
		test_unsupported_modes();
		test_register_masking();
		test_random_traffic();
		settle();
		repeat (PIPE_DRAIN) @(posedge clk);
		symbol_errors += predicted_symbols.size();
		$display("%0d samples demapped, %0d decisions compared, %0d register writes",
			samples_sent, symbols_checked, config_writes);
		$display("covered PAM, PSK and QAM at 2 to 16 points plus unsupported settings");
		if (symbol_errors == 0)
			$display("** min_distance_symbol_demapper_unit: PASSED **");
		else
			$display("** min_distance_symbol_demapper_unit: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
